// ===== rtl/lps_pkg.sv =====
// Shared types and constants for the Legendre polynomial series generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lps_pkg;

    // Field widths of the channels and the configuration register.
    localparam int C_X_W     = 32;
    localparam int C_DEG_W   = 6;
    localparam int C_CNT_W   = 7;
    localparam int C_RECIP_W = 32;

    // Depth of the reciprocal ROM, indexed by degree.
    localparam int C_TABLE_DEPTH = 64;

    // Reset value of the order count register.
    localparam logic [C_CNT_W-1:0] C_ORDER_RESET = 7'd64;

    // One in Q2.30.
    localparam logic signed [C_X_W-1:0] C_Q_ONE = 32'sh4000_0000;

    // Saturation bounds of the Q2.30 result.
    localparam logic signed [43:0] C_SUM_MAX = 44'sd2147483647;
    localparam logic signed [43:0] C_SUM_MIN = -44'sd2147483648;

    // Job queue between the front and the back.
    localparam int C_QUEUE_DEPTH = 2;
    localparam int C_QPTR_W      = 1;
    localparam int C_QFILL_W     = 2;

    localparam logic [63:0] C_TWO32 = 64'h1_0000_0000;

    // Reciprocal ROM: entry l holds round(2^32 / l), ties up; entries 0 and 1 unused.
    localparam logic [C_RECIP_W-1:0] C_RECIP [C_TABLE_DEPTH] = '{
        32'd0, 32'd0,
        32'((C_TWO32 + 64'd1)  / 64'd2),  32'((C_TWO32 + 64'd1)  / 64'd3),
        32'((C_TWO32 + 64'd2)  / 64'd4),  32'((C_TWO32 + 64'd2)  / 64'd5),
        32'((C_TWO32 + 64'd3)  / 64'd6),  32'((C_TWO32 + 64'd3)  / 64'd7),
        32'((C_TWO32 + 64'd4)  / 64'd8),  32'((C_TWO32 + 64'd4)  / 64'd9),
        32'((C_TWO32 + 64'd5)  / 64'd10), 32'((C_TWO32 + 64'd5)  / 64'd11),
        32'((C_TWO32 + 64'd6)  / 64'd12), 32'((C_TWO32 + 64'd6)  / 64'd13),
        32'((C_TWO32 + 64'd7)  / 64'd14), 32'((C_TWO32 + 64'd7)  / 64'd15),
        32'((C_TWO32 + 64'd8)  / 64'd16), 32'((C_TWO32 + 64'd8)  / 64'd17),
        32'((C_TWO32 + 64'd9)  / 64'd18), 32'((C_TWO32 + 64'd9)  / 64'd19),
        32'((C_TWO32 + 64'd10) / 64'd20), 32'((C_TWO32 + 64'd10) / 64'd21),
        32'((C_TWO32 + 64'd11) / 64'd22), 32'((C_TWO32 + 64'd11) / 64'd23),
        32'((C_TWO32 + 64'd12) / 64'd24), 32'((C_TWO32 + 64'd12) / 64'd25),
        32'((C_TWO32 + 64'd13) / 64'd26), 32'((C_TWO32 + 64'd13) / 64'd27),
        32'((C_TWO32 + 64'd14) / 64'd28), 32'((C_TWO32 + 64'd14) / 64'd29),
        32'((C_TWO32 + 64'd15) / 64'd30), 32'((C_TWO32 + 64'd15) / 64'd31),
        32'((C_TWO32 + 64'd16) / 64'd32), 32'((C_TWO32 + 64'd16) / 64'd33),
        32'((C_TWO32 + 64'd17) / 64'd34), 32'((C_TWO32 + 64'd17) / 64'd35),
        32'((C_TWO32 + 64'd18) / 64'd36), 32'((C_TWO32 + 64'd18) / 64'd37),
        32'((C_TWO32 + 64'd19) / 64'd38), 32'((C_TWO32 + 64'd19) / 64'd39),
        32'((C_TWO32 + 64'd20) / 64'd40), 32'((C_TWO32 + 64'd20) / 64'd41),
        32'((C_TWO32 + 64'd21) / 64'd42), 32'((C_TWO32 + 64'd21) / 64'd43),
        32'((C_TWO32 + 64'd22) / 64'd44), 32'((C_TWO32 + 64'd22) / 64'd45),
        32'((C_TWO32 + 64'd23) / 64'd46), 32'((C_TWO32 + 64'd23) / 64'd47),
        32'((C_TWO32 + 64'd24) / 64'd48), 32'((C_TWO32 + 64'd24) / 64'd49),
        32'((C_TWO32 + 64'd25) / 64'd50), 32'((C_TWO32 + 64'd25) / 64'd51),
        32'((C_TWO32 + 64'd26) / 64'd52), 32'((C_TWO32 + 64'd26) / 64'd53),
        32'((C_TWO32 + 64'd27) / 64'd54), 32'((C_TWO32 + 64'd27) / 64'd55),
        32'((C_TWO32 + 64'd28) / 64'd56), 32'((C_TWO32 + 64'd28) / 64'd57),
        32'((C_TWO32 + 64'd29) / 64'd58), 32'((C_TWO32 + 64'd29) / 64'd59),
        32'((C_TWO32 + 64'd30) / 64'd60), 32'((C_TWO32 + 64'd30) / 64'd61),
        32'((C_TWO32 + 64'd31) / 64'd62), 32'((C_TWO32 + 64'd31) / 64'd63)
    };

    // One queued job: the argument and the highest degree to emit.
    typedef struct packed {
        logic signed [C_X_W-1:0]   x;
        logic        [C_DEG_W-1:0] last_deg;
    } t_job;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BE_IDLE,
        BE_EMIT,
        BE_MUL_XP,
        BE_SCALE,
        BE_DIFF,
        BE_RECIP,
        BE_SUM
    } t_be_state;

endpackage

`default_nettype wire

// ===== rtl/lps_in_if.sv =====
// Argument channel: valid/ready handshake carrying one Q2.30 argument word.
// Depends on lps_pkg for field widths.
`default_nettype none

interface lps_in_if;
    import lps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [C_X_W-1:0] arg_x;

    modport source (output valid, output arg_x, input ready);
    modport sink   (input valid, input arg_x, output ready);
endinterface

`default_nettype wire

// ===== rtl/lps_out_if.sv =====
// Result channel: valid/ready handshake carrying degree, value and last flag.
// Depends on lps_pkg for field widths.
`default_nettype none

interface lps_out_if;
    import lps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic        [C_DEG_W-1:0] degree;
    logic signed [C_X_W-1:0]   poly_value;
    logic                      last_of_run;

    modport source (output valid, output degree, output poly_value, output last_of_run,
                    input ready);
    modport sink   (input valid, input degree, input poly_value, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/legendre_polynomial_series.sv =====
// Top level of the Legendre polynomial series generator (Bonnet recurrence).
// Depends on lps_pkg, lps_in_if, lps_out_if, lps_front, lps_queue and lps_back.
//
//   Port          Direction  Contents
//   i_in          sink       argument word: arg_x (signed Q2.30)
//   o_out         source     result word: degree, poly_value (Q2.30), last_of_run
//   i_cfg_we/...  write      order_count register (7 bits)
//
// Each degree from two upward runs six steps through the emit, multiply, scale,
// difference, reciprocal and saturate sequence; degrees zero and one only emit.
// A two-word queue lets the argument side keep accepting during a run.
// Reset is synchronous and active low; the order count resets to 64.
// A stalled result side holds the sequencer at its emit step.
`default_nettype none

module legendre_polynomial_series #(
    parameter int MAX_ORDER = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [lps_pkg::C_CNT_W-1:0] i_cfg_wdata,
    lps_in_if.sink                           i_in,
    lps_out_if.source                        o_out
);
    import lps_pkg::*;

    logic    w_push;
    t_job    w_push_data;
    logic    w_pop;
    t_job    w_head;
    t_q_stat w_q_stat;

    // Front: register, accept and classify.
    lps_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Job queue.
    lps_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_q_stat)
    );

    // Back: recurrence engine and result register.
    lps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/lps_queue.sv =====
// Two-entry job queue between the front and the back of the series generator.
// Depends on lps_pkg for the job and status types.
`default_nettype none

module lps_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lps_pkg::t_job    i_push_data,
    input  wire logic             i_pop,
    output lps_pkg::t_job         o_head,
    output lps_pkg::t_q_stat      o_stat
);
    import lps_pkg::*;

    t_job                 r_slot [C_QUEUE_DEPTH];
    logic [C_QPTR_W-1:0]  r_wr_ptr;
    logic [C_QPTR_W-1:0]  r_rd_ptr;
    logic [C_QFILL_W-1:0] r_fill;

    // Slot storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_fill == C_QFILL_W'(C_QUEUE_DEPTH));
    assign o_stat.empty = (r_fill == '0);

endmodule

`default_nettype wire

// ===== rtl/lps_front.sv =====
// Front end: holds the order count register, accepts arguments and queues jobs.
// Depends on lps_pkg and the lps_in_if interface.
`default_nettype none

module lps_front #(
    parameter int MAX_ORDER = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [lps_pkg::C_CNT_W-1:0] i_cfg_wdata,
    lps_in_if.sink                         i_in,
    input  wire lps_pkg::t_q_stat          i_q_stat,
    output logic                           o_push,
    output lps_pkg::t_job                  o_push_data
);
    import lps_pkg::*;

    localparam logic [C_CNT_W-1:0] C_MAX_CNT  = C_CNT_W'(MAX_ORDER);
    localparam logic [C_DEG_W-1:0] C_MAX_LAST = C_DEG_W'(MAX_ORDER - 1);

    logic [C_CNT_W-1:0] r_order_count;
    logic [C_DEG_W-1:0] w_last_deg;

    // Order count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_count <= C_ORDER_RESET;
        end else if (i_cfg_we) begin
            r_order_count <= i_cfg_wdata;
        end
    end

    // A zero count emits degree zero only; a count above the limit is clipped.
    always_comb begin
        priority if (r_order_count == '0) begin
            w_last_deg = '0;
        end else if (r_order_count > C_MAX_CNT) begin
            w_last_deg = C_MAX_LAST;
        end else begin
            w_last_deg = C_DEG_W'(r_order_count - 1'b1);
        end
    end

    // Accept a word whenever the queue has room.
    assign i_in.ready           = !i_q_stat.full;
    assign o_push               = i_in.valid && !i_q_stat.full;
    assign o_push_data.x        = i_in.arg_x;
    assign o_push_data.last_deg = w_last_deg;

endmodule

`default_nettype wire

// ===== rtl/lps_back.sv =====
// Back end: runs the Bonnet recurrence for one queued job and drives the results.
// Depends on lps_pkg (types, reciprocal ROM) and the lps_out_if interface.
`default_nettype none

module lps_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lps_pkg::t_job    i_head,
    input  wire lps_pkg::t_q_stat i_q_stat,
    output logic                  o_pop,
    lps_out_if.source             o_out
);
    import lps_pkg::*;

    t_be_state r_state;
    t_be_state n_state;

    // Job and recurrence registers.
    logic signed [C_X_W-1:0]     r_x;
    logic        [C_DEG_W-1:0]   r_last_deg;
    logic        [C_DEG_W-1:0]   r_deg;
    logic signed [C_X_W-1:0]     r_cur;
    logic signed [C_X_W-1:0]     r_p1;
    logic signed [C_X_W-1:0]     r_p2;

    // Datapath pipeline registers.
    logic signed [63:0]          r_prod;
    logic signed [41:0]          r_ta;
    logic signed [38:0]          r_tb;
    logic signed [41:0]          r_n;
    logic        [63:0]          r_lo_prod;
    logic signed [42:0]          r_hi_prod;

    // Output register.
    logic                        r_out_valid;
    logic        [C_DEG_W-1:0]   r_out_deg;
    logic signed [C_X_W-1:0]     r_out_val;
    logic                        r_out_last;

    // Combinational datapath.
    logic                        w_slot_free;
    logic                        w_emit;
    logic signed [63:0]          w_prod;
    logic signed [33:0]          w_a;
    logic signed [7:0]           w_coef_a;
    logic signed [6:0]           w_coef_b;
    logic signed [41:0]          w_ta;
    logic signed [38:0]          w_tb;
    logic        [C_RECIP_W-1:0] w_recip;
    logic        [63:0]          w_lo_prod;
    logic signed [9:0]           w_hi;
    logic signed [42:0]          w_hi_prod;
    logic signed [43:0]          w_sum;
    logic signed [C_X_W-1:0]     w_sat;

    assign w_slot_free = !r_out_valid || o_out.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BE_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = BE_EMIT;
                end
            end
            BE_EMIT: begin
                if (w_slot_free) begin
                    priority if (r_deg == r_last_deg) begin
                        n_state = BE_IDLE;
                    end else if (r_deg == '0) begin
                        n_state = BE_EMIT;
                    end else begin
                        n_state = BE_MUL_XP;
                    end
                end
            end
            BE_MUL_XP: n_state = BE_SCALE;
            BE_SCALE:  n_state = BE_DIFF;
            BE_DIFF:   n_state = BE_RECIP;
            BE_RECIP:  n_state = BE_SUM;
            BE_SUM:    n_state = BE_EMIT;
            default:   n_state = BE_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_pop  = 1'b0;
        w_emit = 1'b0;
        unique case (r_state)
            BE_IDLE: o_pop  = !i_q_stat.empty;
            BE_EMIT: w_emit = w_slot_free;
            default: begin
                o_pop  = 1'b0;
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Step one: x * P(l-1), then floor by 2^30.
    assign w_prod = r_x * r_p1;
    assign w_a    = r_prod[63:30];

    // Step two: the two small coefficient products (2l-1)*A and (l-1)*P(l-2).
    assign w_coef_a = $signed({1'b0, r_deg, 1'b0}) - 8'sd1;
    assign w_coef_b = $signed({1'b0, r_deg}) - 7'sd1;
    assign w_ta     = w_a * w_coef_a;
    assign w_tb     = r_p2 * w_coef_b;

    // Step four: N * (1/l) split into a low unsigned and a high signed part.
    assign w_recip   = C_RECIP[r_deg];
    assign w_lo_prod = 64'(r_n[31:0]) * 64'(w_recip);
    assign w_hi      = r_n[41:32];
    assign w_hi_prod = w_hi * $signed({1'b0, w_recip});

    // Step five: combine the halves and saturate to Q2.30.
    assign w_sum = 44'(r_hi_prod) + $signed({12'd0, r_lo_prod[63:32]});
    always_comb begin
        priority if (w_sum > C_SUM_MAX) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_sum < C_SUM_MIN) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    // Datapath registers, advanced by the sequencer state.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BE_IDLE: begin
                r_x        <= i_head.x;
                r_last_deg <= i_head.last_deg;
                r_deg      <= '0;
                r_cur      <= C_Q_ONE;
            end
            BE_EMIT: begin
                if (w_slot_free) begin
                    r_p2  <= r_p1;
                    r_p1  <= r_cur;
                    r_deg <= r_deg + 1'b1;
                    if (r_deg == '0) begin
                        r_cur <= r_x;
                    end
                end
            end
            BE_MUL_XP: r_prod <= w_prod;
            BE_SCALE: begin
                r_ta <= w_ta;
                r_tb <= w_tb;
            end
            BE_DIFF:   r_n <= r_ta - 42'(r_tb);
            BE_RECIP: begin
                r_lo_prod <= w_lo_prod;
                r_hi_prod <= w_hi_prod;
            end
            BE_SUM:    r_cur <= w_sat;
            default: begin
                r_cur <= r_cur;
            end
        endcase
    end

    // Output register: loads a result word, holds it until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_deg  <= r_deg;
            r_out_val  <= r_cur;
            r_out_last <= (r_deg == r_last_deg);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.degree      = r_out_deg;
    assign o_out.poly_value  = r_out_val;
    assign o_out.last_of_run = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/lps_checker.sv =====
// Port-level checks for the Legendre polynomial series generator, bound to the top.
// Depends on lps_pkg for widths and the Q2.30 one constant.
`default_nettype none

module lps_checker #(
    parameter int MAX_ORDER = 64
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_cfg_we,
    input wire logic [lps_pkg::C_CNT_W-1:0] i_cfg_wdata,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [lps_pkg::C_DEG_W-1:0] i_out_degree,
    input wire logic [lps_pkg::C_X_W-1:0]   i_out_value,
    input wire logic                        i_out_last
);
    import lps_pkg::*;

    logic                 w_out_take;
    logic [C_DEG_W-1:0]   r_exp_deg;
    logic [C_DEG_W-1:0]   r_exp_last;

    assign w_out_take = i_out_valid && i_out_ready;

    // Expected degree of the next result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_deg <= '0;
        end else if (w_out_take) begin
            r_exp_deg <= i_out_last ? '0 : i_out_degree + 1'b1;
        end
    end

    // Expected final degree, tracked from the register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_last <= C_DEG_W'(MAX_ORDER - 1);
        end else if (i_cfg_we) begin
            if (i_cfg_wdata == '0) begin
                r_exp_last <= '0;
            end else if (i_cfg_wdata > C_CNT_W'(MAX_ORDER)) begin
                r_exp_last <= C_DEG_W'(MAX_ORDER - 1);
            end else begin
                r_exp_last <= C_DEG_W'(i_cfg_wdata - 1'b1);
            end
        end
    end

    // Degrees run upward from zero within each run.
    a_deg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take |-> (i_out_degree == r_exp_deg))
        else $error("result degree out of sequence");

    // The last flag comes exactly at the final degree set by the clipped order count.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take |-> (i_out_last == (i_out_degree == r_exp_last)))
        else $error("last flag at the wrong degree");

    // Degree zero is always one.
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && (i_out_degree == '0)) |-> (i_out_value == C_Q_ONE))
        else $error("degree zero value is not one");

    // A stalled result word holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_degree) && $stable(i_out_value)
             && $stable(i_out_last)))
        else $error("stalled result word changed");

endmodule

bind legendre_polynomial_series lps_checker #(
    .MAX_ORDER (MAX_ORDER)
) u_lps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_wdata  (i_cfg_wdata),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_degree (o_out.degree),
    .i_out_value  (o_out.poly_value),
    .i_out_last   (o_out.last_of_run)
);

`default_nettype wire

// ===== sim/lps_tb_pkg.sv =====
// Scoreboard for the Legendre polynomial series generator testbench.
// Depends on lps_pkg for field widths and the table depth.
`timescale 1ns / 1ps

package lps_tb_pkg;
    import lps_pkg::*;

    // One expected result word and the argument that caused it.
    typedef struct {
        int unsigned               arg_id;
        logic signed [C_X_W-1:0]   arg;
        logic        [C_DEG_W-1:0] degree;
        logic signed [C_X_W-1:0]   value;
        logic                      last;
    } t_term;

    class legendre_scoreboard;
        localparam int C_REPORT_LIMIT = 10;
        localparam logic signed [127:0] C_Q_MAX = 128'sd2147483647;
        localparam logic signed [127:0] C_Q_MIN = -128'sd2147483648;

        logic [C_CNT_W-1:0]   order_count;
        logic [C_RECIP_W-1:0] recip_q032 [C_TABLE_DEPTH];
        t_term                expected_terms [$];
        int unsigned          args_noted;
        int unsigned          terms_checked;
        int unsigned          mismatches;

        function new();
            order_count   = C_ORDER_RESET;
            args_noted    = 0;
            terms_checked = 0;
            mismatches    = 0;
            // Entry l is 2^32 / l rounded to nearest, ties up; the first two are unused.
            for (int l = 0; l < C_TABLE_DEPTH; l++) begin
                if (l < 2) begin
                    recip_q032[l] = '0;
                end else begin
                    recip_q032[l] = 32'(((64'd1 << 32) + 64'(l / 2)) / 64'(l));
                end
            end
        endfunction

        function void set_order_count(logic [C_CNT_W-1:0] count);
            order_count = count;
        endfunction

        function int unsigned pending();
            return expected_terms.size();
        endfunction

        // Bonnet recurrence in Q2.30 for one accepted argument.
        function void note_argument(logic signed [C_X_W-1:0] x);
            int                  run_len;
            logic signed [63:0]  prev1;
            logic signed [63:0]  prev2;
            logic signed [63:0]  cur;
            logic signed [63:0]  x_times_prev;
            logic signed [63:0]  numer;
            logic signed [127:0] wide;
            t_term               term;

            // A count of zero still emits P_0; counts above the table depth are clipped.
            run_len = int'(order_count);
            if (run_len < 1) begin
                run_len = 1;
            end
            if (run_len > C_TABLE_DEPTH) begin
                run_len = C_TABLE_DEPTH;
            end
            prev1 = '0;
            prev2 = '0;
            for (int deg = 0; deg < run_len; deg++) begin
                if (deg == 0) begin
                    cur = 64'(C_Q_ONE);
                end else if (deg == 1) begin
                    cur = x;
                end else begin
                    // Both shifts are arithmetic, so they round toward minus infinity.
                    x_times_prev = x * prev1;
                    numer = (2 * deg - 1) * (x_times_prev >>> 30) - (deg - 1) * prev2;
                    wide = numer * $signed({1'b0, recip_q032[deg]});
                    wide = wide >>> 32;
                    if (wide > C_Q_MAX) begin
                        cur = 64'(C_Q_MAX);
                    end else if (wide < C_Q_MIN) begin
                        cur = 64'(C_Q_MIN);
                    end else begin
                        cur = wide[63:0];
                    end
                end
                term.arg_id = args_noted;
                term.arg    = x;
                term.degree = deg[C_DEG_W-1:0];
                term.value  = cur[C_X_W-1:0];
                term.last   = (deg + 1 == run_len);
                expected_terms.push_back(term);
                prev2 = prev1;
                prev1 = cur;
            end
            args_noted++;
        endfunction

        // Compares one accepted result word with the oldest expectation.
        function void check_term(logic [C_DEG_W-1:0] degree, logic signed [C_X_W-1:0] value,
                                 logic last);
            t_term want;

            if (expected_terms.size() == 0) begin
                mismatches++;
                if (mismatches <= C_REPORT_LIMIT) begin
                    $display("unexpected word: degree %0d value %h last %b",
                             degree, value, last);
                end
                return;
            end
            want = expected_terms.pop_front();
            terms_checked++;
            if (degree !== want.degree || value !== want.value || last !== want.last) begin
                mismatches++;
                if (mismatches <= C_REPORT_LIMIT) begin
                    $display(
                        "mismatch on arg %0d (x=%h): exp %0d/%h/%b, got %0d/%h/%b",
                        want.arg_id, want.arg, want.degree, want.value, want.last,
                        degree, value, last);
                end
            end
        endfunction
    endclass

endpackage

// ===== sim/tb_legendre_polynomial_series.sv =====
// Testbench top for the Legendre polynomial series generator.
// Depends on lps_pkg, lps_in_if, lps_out_if, lps_tb_pkg and the block itself.
`timescale 1ns / 1ps

module tb_legendre_polynomial_series;
    import lps_pkg::*;
    import lps_tb_pkg::*;

    localparam int C_HALF_PERIOD     = 6;
    localparam int C_RESET_CYCLES    = 7;
    localparam int C_SETTLE_CYCLES   = 12;
    localparam int C_HOLD_CYCLES     = 300;
    localparam int C_IDLE_LIMIT      = 4000;
    localparam int C_RANDOM_PHASES   = 10;
    localparam int C_ITEMS_PER_PHASE = 29;
    localparam int C_MAX_GAP         = 6;

    localparam logic signed [C_X_W-1:0] C_NEG_ONE = -C_Q_ONE;
    localparam logic signed [C_X_W-1:0] C_HALF    = 32'sh2000_0000;
    localparam logic signed [C_X_W-1:0] C_X_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [C_X_W-1:0] C_X_MIN   = 32'sh8000_0000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [C_CNT_W-1:0] i_cfg_wdata;

    lps_in_if  arg_ch ();
    lps_out_if term_ch ();

    legendre_scoreboard sb = new();

    bit          steady_flow;
    bit          hold_request;
    int unsigned settings_written;
    int unsigned idle_cycles;

    legendre_polynomial_series u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (arg_ch),
        .o_out       (term_ch)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #(C_HALF_PERIOD) i_clk = ~i_clk;

    // Monitors: note accepted arguments and check accepted result words.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (arg_ch.valid && arg_ch.ready) begin
                sb.note_argument(arg_ch.arg_x);
            end
            if (term_ch.valid && term_ch.ready) begin
                sb.check_term(term_ch.degree, term_ch.poly_value, term_ch.last_of_run);
            end
        end
    end

    // Watchdog on cycles in which no word moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (arg_ch.valid && arg_ch.ready) || (term_ch.valid && term_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= C_IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random ready gaps, plus one long hold-off on request.
    initial begin : result_sink
        int gap;

        term_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                term_ch.ready <= 1'b0;
                repeat (C_HOLD_CYCLES) @(negedge i_clk);
            end
            gap = steady_flow ? 0 : $urandom_range(0, C_MAX_GAP);
            if (gap > 0) begin
                term_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            term_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!term_ch.valid);
            @(negedge i_clk);
        end
    end

    // Offers one argument word after a random gap, or none in steady flow; returns at
    // the falling edge after acceptance with valid still high.
    task automatic send_arg(input logic signed [C_X_W-1:0] x);
        int gap;

        gap = steady_flow ? 0 : $urandom_range(0, C_MAX_GAP);
        if (gap > 0) begin
            arg_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        arg_ch.valid <= 1'b1;
        arg_ch.arg_x <= x;
        do @(posedge i_clk); while (!arg_ch.ready);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every expected word has arrived.
    task automatic drain_results();
        arg_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Register write while the block is idle.
    task automatic write_order_count(input logic [C_CNT_W-1:0] count);
        drain_results();
        repeat (C_SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_order_count(count);
        settings_written++;
    endtask

    // Mostly short runs, sometimes medium, rarely the extremes and beyond.
    function automatic logic [C_CNT_W-1:0] pick_order_count();
        int pick;

        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            return C_CNT_W'($urandom_range(1, 12));
        end else if (pick < 9) begin
            return C_CNT_W'($urandom_range(13, 40));
        end
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return C_CNT_W'(C_TABLE_DEPTH);
            default: return C_CNT_W'($urandom_range(C_TABLE_DEPTH + 1, 127));
        endcase
    endfunction

    // Mostly arguments in [-1,1], some exact landmarks, some full-range words.
    function automatic logic signed [C_X_W-1:0] pick_arg();
        int unsigned r;

        case ($urandom_range(0, 15))
            0:       return C_Q_ONE;
            1:       return C_NEG_ONE;
            2, 3:    return $urandom;
            default: begin
                r = $urandom_range(0, 32'h8000_0000);
                return r - 32'h4000_0000;
            end
        endcase
    endfunction

    // Stimulus.
    initial begin : stimulus
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        arg_ch.valid     = 1'b0;
        arg_ch.arg_x     = '0;
        steady_flow      = 1'b0;
        hold_request     = 1'b0;
        settings_written = 0;
        repeat (C_RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset order count: landmarks and field extremes.
        send_arg(C_Q_ONE);
        send_arg(C_NEG_ONE);
        send_arg('0);
        send_arg(C_X_MAX);
        send_arg(C_X_MIN);
        send_arg(C_HALF);
        send_arg(32'shFFFF_FFFF);
        send_arg(32'sh0000_0001);

        // A count of zero emits P_0 only.
        write_order_count('0);
        send_arg(pick_arg());
        send_arg(C_X_MIN);
        write_order_count(7'd1);
        send_arg(C_HALF);
        write_order_count(7'd2);
        send_arg(C_NEG_ONE);
        send_arg(C_X_MAX);
        // Counts above the table depth are clipped.
        write_order_count(7'd65);
        send_arg(pick_arg());
        write_order_count(7'd127);
        send_arg(C_HALF);
        // Arguments outside [-1,1] saturate.
        write_order_count(7'd3);
        send_arg(C_Q_ONE);
        send_arg(32'sh5FFF_FFFF);

        // Random phases, each at its own order count.
        for (int phase = 0; phase < C_RANDOM_PHASES; phase++) begin
            write_order_count(phase == 1 ? C_CNT_W'(C_TABLE_DEPTH) : pick_order_count());
            steady_flow = (phase == 3);
            for (int item = 0; item < C_ITEMS_PER_PHASE; item++) begin
                if (phase == 5 && item == 4) begin
                    hold_request = 1'b1;
                end
                if (phase == 7 && item == 14) begin
                    drain_results();
                    @(negedge i_clk);
                end
                send_arg(pick_arg());
            end
        end
        steady_flow = 1'b0;

        // Let the last runs finish, then report.
        drain_results();
        repeat (20) @(negedge i_clk);
        $display("Run covered %0d arguments and %0d result words over %0d register settings.",
                 sb.args_noted, sb.terms_checked, settings_written);
        $display("Mismatches: %0d, words still expected: %0d.", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== legendre_polynomial_series.f =====
rtl/lps_pkg.sv
rtl/lps_in_if.sv
rtl/lps_out_if.sv
rtl/lps_queue.sv
rtl/lps_front.sv
rtl/lps_back.sv
rtl/legendre_polynomial_series.sv
rtl/lps_checker.sv
sim/lps_tb_pkg.sv
sim/tb_legendre_polynomial_series.sv
